[rtl/core/wrht_pkg.sv]
// ----------------------------------------------------------------------------
// wrht_pkg
// Shared types and constants of the wireframe rectangle hit test core.
// ----------------------------------------------------------------------------
`default_nettype none

package wrht_pkg;

   localparam int CSR_INDEX_WIDTH = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RECT_MIN_X = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RECT_MIN_Y = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RECT_MAX_X = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RECT_MAX_Y = 8'd3;

   typedef enum logic [1:0] {
      REGION_BELOW,
      REGION_INSIDE,
      REGION_ABOVE
   } region_type;

   typedef struct packed {
      logic counted;
      logic last;
      logic decided;
      logic decided_hit;
   } edge_ctrl_type;

endpackage

`default_nettype wire

[rtl/core/wrht_front.sv]
// ----------------------------------------------------------------------------
// wrht_front
// Classifies both endpoints of an edge into the nine rectangle regions,
// settles the easy cases and prepares the corner offsets for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wrht_front
   import wrht_pkg::*;
#(
   parameter int CW = 16
) (
   input  wire logic signed [CW-1:0] p_x,
   input  wire logic signed [CW-1:0] p_y,
   input  wire logic signed [CW-1:0] q_x,
   input  wire logic signed [CW-1:0] q_y,
   input  wire logic                 p_in_front,
   input  wire logic                 q_in_front,
   input  wire logic                 last_edge,
   input  wire logic signed [CW-1:0] rect_min_x,
   input  wire logic signed [CW-1:0] rect_min_y,
   input  wire logic signed [CW-1:0] rect_max_x,
   input  wire logic signed [CW-1:0] rect_max_y,
   output edge_ctrl_type             ctrl,
   output logic signed [CW:0]        dx,
   output logic signed [CW:0]        dy,
   output logic signed [CW:0]        ox0,
   output logic signed [CW:0]        ox1,
   output logic signed [CW:0]        oy0,
   output logic signed [CW:0]        oy1
);

   function automatic region_type classify(logic signed [CW-1:0] v,
                                           logic signed [CW-1:0] lo,
                                           logic signed [CW-1:0] hi);
      region_type r;
      if (v < lo) begin
         r = REGION_BELOW;
      end else if (v <= hi) begin
         r = REGION_INSIDE;
      end else begin
         r = REGION_ABOVE;
      end
      return r;
   endfunction

   function automatic logic signed [CW:0] sub_ext(logic signed [CW-1:0] a,
                                                  logic signed [CW-1:0] b);
      logic signed [CW:0] ae;
      logic signed [CW:0] be;
      ae = $signed({a[CW-1], a});
      be = $signed({b[CW-1], b});
      return ae - be;
   endfunction

   region_type pc, pr, qc, qr;
   logic       end_inside, both_miss, both_span;

   always_comb begin
      pc = classify(p_x, rect_min_x, rect_max_x);
      pr = classify(p_y, rect_min_y, rect_max_y);
      qc = classify(q_x, rect_min_x, rect_max_x);
      qr = classify(q_y, rect_min_y, rect_max_y);

      end_inside = (pc == REGION_INSIDE && pr == REGION_INSIDE) ||
                   (qc == REGION_INSIDE && qr == REGION_INSIDE);
      both_miss  = (pr == REGION_BELOW && qr == REGION_BELOW) ||
                   (pc == REGION_BELOW && qc == REGION_BELOW) ||
                   (pr == REGION_ABOVE && qr == REGION_ABOVE) ||
                   (pc == REGION_ABOVE && qc == REGION_ABOVE);
      both_span  = (pr == REGION_INSIDE && qr == REGION_INSIDE) ||
                   (pc == REGION_INSIDE && qc == REGION_INSIDE);

      ctrl.counted     = p_in_front | q_in_front;
      ctrl.last        = last_edge;
      ctrl.decided     = end_inside | both_miss | both_span;
      ctrl.decided_hit = end_inside | (~both_miss & both_span);

      dx  = sub_ext(p_x, q_x);
      dy  = sub_ext(p_y, q_y);
      ox0 = sub_ext(rect_min_x, q_x);
      ox1 = sub_ext(rect_max_x, q_x);
      oy0 = sub_ext(rect_min_y, q_y);
      oy1 = sub_ext(rect_max_y, q_y);
   end

endmodule

`default_nettype wire

[rtl/core/wrht_queue.sv]
// ----------------------------------------------------------------------------
// wrht_queue
// Two-entry queue of classified edges between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wrht_queue #(
   parameter int DATA_WIDTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [DATA_WIDTH-1:0] push_data,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       head_valid,
   output logic [DATA_WIDTH-1:0]      head_data
);

   logic [1:0]            count_ff, count_in;
   logic [DATA_WIDTH-1:0] slot0_ff, slot0_in;
   logic [DATA_WIDTH-1:0] slot1_ff, slot1_in;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push && pop) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end
      end else if (push) begin
         count_in = count_ff + 2'd1;
         if (count_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = slot0_ff;

endmodule

`default_nettype wire

[rtl/core/wrht_back.sv]
// ----------------------------------------------------------------------------
// wrht_back
// Forms the corner cross products, resolves the corner test, keeps the
// running hit flag and holds the object result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wrht_back
   import wrht_pkg::*;
#(
   parameter int CW = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire edge_ctrl_type        head_ctrl,
   input  wire logic signed [CW:0]   dx,
   input  wire logic signed [CW:0]   dy,
   input  wire logic signed [CW:0]   ox0,
   input  wire logic signed [CW:0]   ox1,
   input  wire logic signed [CW:0]   oy0,
   input  wire logic signed [CW:0]   oy1,
   output logic                      pop,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   input  wire logic                 rsp_ready
);

   localparam int PW = 2 * CW + 2;

   logic                 mul_valid_ff, mul_valid_in;
   edge_ctrl_type        mul_ctrl_ff;
   logic signed [PW-1:0] dy_ox0_ff, dy_ox1_ff, dx_oy0_ff, dx_oy1_ff;
   logic                 hit_ff, hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 retire, corner_hit, edge_hit;
   logic                 below00, below11, below01, below10;

   always_comb begin
      below00    = dy_ox0_ff < dx_oy0_ff;
      below11    = dy_ox1_ff < dx_oy1_ff;
      below01    = dy_ox0_ff < dx_oy1_ff;
      below10    = dy_ox1_ff < dx_oy0_ff;
      corner_hit = (below00 != below11) || (below01 != below10);
      edge_hit   = mul_ctrl_ff.counted &
                   (mul_ctrl_ff.decided ? mul_ctrl_ff.decided_hit : corner_hit);

      retire = mul_valid_ff && (!mul_ctrl_ff.last || !rsp_valid_ff || rsp_ready);
      pop    = head_valid && (!mul_valid_ff || retire);

      mul_valid_in = pop | (mul_valid_ff & ~retire);

      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      if (retire) begin
         if (mul_ctrl_ff.last) begin
            rsp_valid_in = 1'b1;
            rsp_hit_in   = hit_ff | edge_hit;
            hit_in       = 1'b0;
         end else begin
            hit_in = hit_ff | edge_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff <= rsp_hit_in;
      if (pop) begin
         mul_ctrl_ff <= head_ctrl;
         dy_ox0_ff   <= dy * ox0;
         dy_ox1_ff   <= dy * ox1;
         dx_oy0_ff   <= dx * oy0;
         dx_oy1_ff   <= dx * oy1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

endmodule

`default_nettype wire

[rtl/core/wireframe_rectangle_hit_test_core.sv]
// ----------------------------------------------------------------------------
// wireframe_rectangle_hit_test_core
// Tests the screen edges of an object against a selection rectangle and
// reports one hit result per object on its last edge.
// ----------------------------------------------------------------------------
// Throughput is one edge request per cycle while the object result is not held
// waiting on rsp_tready, set by the single cross product stage that takes one edge from the queue each cycle.
// The last edge of an object passes the edge queue and the cross product stage before its result is registered.
// Reset is synchronous and active high; it clears the rectangle registers,
// the queue, the hit flag and the pending result.
`default_nettype none

module wireframe_rectangle_hit_test_core
   import wrht_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // req_tdata: p_x, p_y, q_x, q_y, p_in_front, q_in_front, zero fill
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   input  wire logic [((4*COORD_WIDTH+2+7)/8)*8-1:0]     req_tdata,
   input  wire logic                                     req_tlast,
   // rsp_tdata: object_hit, zero fill
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   output logic [7:0]                                    rsp_tdata,
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]               csr_index,
   input  wire logic [COORD_WIDTH-1:0]                   csr_data
);

   localparam int CW = COORD_WIDTH;
   localparam int QW = $bits(edge_ctrl_type) + 6 * (CW + 1);

   logic signed [CW-1:0] rect_min_x_ff, rect_min_y_ff, rect_max_x_ff, rect_max_y_ff;

   edge_ctrl_type        f_ctrl, q_ctrl;
   logic signed [CW:0]   f_dx, f_dy, f_ox0, f_ox1, f_oy0, f_oy1;
   logic signed [CW:0]   q_dx, q_dy, q_ox0, q_ox1, q_oy0, q_oy1;
   logic [QW-1:0]        q_data;
   logic                 q_full, q_valid, q_pop, req_accept;
   logic                 rsp_hit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_min_x_ff <= '0;
         rect_min_y_ff <= '0;
         rect_max_x_ff <= '0;
         rect_max_y_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RECT_MIN_X: rect_min_x_ff <= csr_data;
            CSR_RECT_MIN_Y: rect_min_y_ff <= csr_data;
            CSR_RECT_MAX_X: rect_max_x_ff <= csr_data;
            CSR_RECT_MAX_Y: rect_max_y_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   wrht_front #(.CW(CW)) u_front (
      .p_x        (req_tdata[CW-1:0]),
      .p_y        (req_tdata[2*CW-1:CW]),
      .q_x        (req_tdata[3*CW-1:2*CW]),
      .q_y        (req_tdata[4*CW-1:3*CW]),
      .p_in_front (req_tdata[4*CW]),
      .q_in_front (req_tdata[4*CW+1]),
      .last_edge  (req_tlast),
      .rect_min_x (rect_min_x_ff),
      .rect_min_y (rect_min_y_ff),
      .rect_max_x (rect_max_x_ff),
      .rect_max_y (rect_max_y_ff),
      .ctrl       (f_ctrl),
      .dx         (f_dx),
      .dy         (f_dy),
      .ox0        (f_ox0),
      .ox1        (f_ox1),
      .oy0        (f_oy0),
      .oy1        (f_oy1)
   );

   assign req_tready = ~q_full;
   assign req_accept = req_tvalid & req_tready;

   wrht_queue #(.DATA_WIDTH(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_data  ({f_ctrl, f_dx, f_dy, f_ox0, f_ox1, f_oy0, f_oy1}),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_data)
   );

   assign {q_ctrl, q_dx, q_dy, q_ox0, q_ox1, q_oy0, q_oy1} = q_data;

   wrht_back #(.CW(CW)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_ctrl  (q_ctrl),
      .dx         (q_dx),
      .dy         (q_dy),
      .ox0        (q_ox0),
      .ox1        (q_ox1),
      .oy0        (q_oy0),
      .oy1        (q_oy1),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_hit    (rsp_hit),
      .rsp_ready  (rsp_tready)
   );

   assign rsp_tdata = {7'd0, rsp_hit};

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Streams object edges into the wireframe rectangle hit test core and checks
// every object result against a predictor kept beside the block. Directed
// edges cover the region shortcuts, the corner test, the in-front flags and
// the coordinate extremes; random objects follow under several rectangles,
// inverted and full-range ones among them, with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import wrht_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_EDGES = 80;

   class hit_tracker;
      logic signed [15:0] rect_lo_x, rect_lo_y, rect_hi_x, rect_hi_y;
      logic hit_so_far;
      logic expected_hits[$];
      int errors;

      function new();
         rect_lo_x = '0;
         rect_lo_y = '0;
         rect_hi_x = '0;
         rect_hi_y = '0;
         hit_so_far = 1'b0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [15:0] value);
         case (index)
            CSR_RECT_MIN_X: rect_lo_x = value;
            CSR_RECT_MIN_Y: rect_lo_y = value;
            CSR_RECT_MAX_X: rect_hi_x = value;
            CSR_RECT_MAX_Y: rect_hi_y = value;
            default: ;
         endcase
      endfunction

      function region_type classify(longint v, longint lo, longint hi);
         if (v < lo) return REGION_BELOW;
         if (v <= hi) return REGION_INSIDE;
         return REGION_ABOVE;
      endfunction

      function bit below_line(longint dx, longint dy, longint qx, longint qy,
                              longint cx, longint cy);
         return dy * (cx - qx) < dx * (cy - qy);
      endfunction

      function bit edge_touches(longint px, longint py, longint qx, longint qy);
         region_type pc, pr, qc, qr;
         longint dx, dy;
         pc = classify(px, rect_lo_x, rect_hi_x);
         pr = classify(py, rect_lo_y, rect_hi_y);
         qc = classify(qx, rect_lo_x, rect_hi_x);
         qr = classify(qy, rect_lo_y, rect_hi_y);
         if ((pc == REGION_INSIDE && pr == REGION_INSIDE) ||
             (qc == REGION_INSIDE && qr == REGION_INSIDE))
            return 1'b1;
         if ((pr == REGION_BELOW && qr == REGION_BELOW) ||
             (pc == REGION_BELOW && qc == REGION_BELOW) ||
             (pr == REGION_ABOVE && qr == REGION_ABOVE) ||
             (pc == REGION_ABOVE && qc == REGION_ABOVE))
            return 1'b0;
         if ((pr == REGION_INSIDE && qr == REGION_INSIDE) ||
             (pc == REGION_INSIDE && qc == REGION_INSIDE))
            return 1'b1;
         dx = px - qx;
         dy = py - qy;
         if (below_line(dx, dy, qx, qy, rect_lo_x, rect_lo_y) !=
             below_line(dx, dy, qx, qy, rect_hi_x, rect_hi_y))
            return 1'b1;
         if (below_line(dx, dy, qx, qy, rect_lo_x, rect_hi_y) !=
             below_line(dx, dy, qx, qy, rect_hi_x, rect_lo_y))
            return 1'b1;
         return 1'b0;
      endfunction

      function void note_edge(logic signed [15:0] px, logic signed [15:0] py,
                              logic signed [15:0] qx, logic signed [15:0] qy,
                              logic p_front, logic q_front, logic last);
         if ((p_front || q_front) && edge_touches(px, py, qx, qy))
            hit_so_far = 1'b1;
         if (last) begin
            expected_hits.push_back(hit_so_far);
            hit_so_far = 1'b0;
         end
      endfunction

      function void check_object(logic actual);
         logic want;
         if (expected_hits.size() == 0) begin
            $error("object_hit with no object pending: expected none, actual %0d", actual);
            errors++;
         end else begin
            want = expected_hits.pop_front();
            if (actual !== want) begin
               $error("object_hit mismatch: expected %0d, actual %0d", want, actual);
               errors++;
            end
         end
      endfunction

      function int outstanding();
         return expected_hits.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   hit_tracker tracker = new();

   int req_idle_pct = 34;
   int rsp_idle_pct = 34;
   logic hold_trigger = 1'b0;
   logic hold_seen = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;
   int cur_min_x, cur_min_y, cur_max_x, cur_max_y;

   wireframe_rectangle_hit_test_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // The receiver checks each accepted result and stalls at random; a toggle
   // of hold_trigger makes it hold off for a long stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            tracker.check_object(rsp_tdata[0]);
         if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= 300;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_edge(input int px, input int py, input int qx, input int qy,
                            input int pf, input int qf, input int last);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, qf[0], pf[0], qy[15:0], qx[15:0], py[15:0], px[15:0]};
      req_tlast <= last[0];
      do @(posedge clock); while (!req_tready);
      tracker.note_edge(px[15:0], py[15:0], qx[15:0], qy[15:0], pf[0], qf[0], last[0]);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index, input int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value[15:0];
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(index, value[15:0]);
   endtask

   task automatic set_rect(input int x0, input int y0, input int x1, input int y1);
      settle();
      write_csr(CSR_RECT_MIN_X, x0);
      write_csr(CSR_RECT_MIN_Y, y0);
      write_csr(CSR_RECT_MAX_X, x1);
      write_csr(CSR_RECT_MAX_Y, y1);
      csr_valid <= 1'b0;
      cur_min_x = x0;
      cur_min_y = y0;
      cur_max_x = x1;
      cur_max_y = y1;
   endtask

   function automatic logic [15:0] pick_coord(int lo, int hi);
      int mode;
      int base;
      int span;
      mode = $urandom_range(0, 9);
      base = (lo < hi) ? lo : hi;
      span = (lo < hi) ? hi - lo : lo - hi;
      if (mode < 2) return 16'($urandom);
      if (mode == 2) return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      if (mode < 5) return 16'(base + int'($urandom_range(0, span)));
      base = $urandom_range(0, 1) ? lo : hi;
      return 16'(base + int'($urandom_range(0, 160)) - 80);
   endfunction

   task automatic send_random_object(input int max_len, inout int edges);
      int len;
      int sel;
      logic pf, qf;
      len = $urandom_range(1, max_len);
      for (int e = 0; e < len; e++) begin
         sel = $urandom_range(0, 99);
         if (sel < 12) {pf, qf} = 2'b00;
         else if (sel < 26) {pf, qf} = 2'b01;
         else if (sel < 40) {pf, qf} = 2'b10;
         else {pf, qf} = 2'b11;
         send_edge(int'(pick_coord(cur_min_x, cur_max_x)),
                   int'(pick_coord(cur_min_y, cur_max_y)),
                   int'(pick_coord(cur_min_x, cur_max_x)),
                   int'(pick_coord(cur_min_y, cur_max_y)),
                   int'(pf), int'(qf), int'(e == len - 1));
      end
      edges += len;
   endtask

   initial begin
      int edges;
      int x0, y0, x1, y1;
      bit paused;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset rectangle is the single point at the origin.
      send_edge(0, 0, 0, 0, 1, 1, 1);
      send_edge(1, 1, 5, 5, 1, 1, 1);

      set_rect(-100, -50, 100, 50);
      send_edge(0, 0, 1000, 1000, 1, 1, 1);
      send_edge(-1000, -1000, 10, 10, 1, 1, 1);
      send_edge(-200, -10, -150, 30, 1, 1, 1);
      send_edge(-10, -80, 50, -70, 1, 1, 1);
      send_edge(200, 0, 300, 10, 1, 1, 0);
      send_edge(0, 60, 10, 90, 1, 1, 1);
      send_edge(0, -200, 0, 200, 1, 1, 1);
      send_edge(-300, 0, 300, 0, 1, 1, 1);
      send_edge(-200, 0, 0, -200, 1, 1, 1);
      send_edge(-150, 0, 0, -150, 1, 1, 1);
      send_edge(-150, 0, 0, -120, 1, 1, 1);
      send_edge(0, 0, 1, 1, 0, 0, 1);
      send_edge(0, 0, 5, 5, 0, 1, 1);
      send_edge(0, 0, 5, 5, 1, 0, 1);
      send_edge(0, 0, 5, 5, 1, 1, 0);
      send_edge(-200, -10, -150, 30, 1, 1, 0);
      send_edge(0, 0, 5, 5, 0, 0, 1);
      send_edge(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1, 1, 1);
      send_edge(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1, 1, 1);
      send_edge(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1, 1, 1);

      set_rect(100, 50, -100, -50);
      send_edge(0, 0, 0, 0, 1, 1, 1);
      send_edge(200, 0, -200, 0, 1, 1, 1);

      for (int phase = 0; phase < 7; phase++) begin
         x0 = int'($urandom_range(0, 60000)) - 30000;
         y0 = int'($urandom_range(0, 60000)) - 30000;
         x1 = x0 + int'($urandom_range(0, 400));
         y1 = y0 + int'($urandom_range(0, 400));
         case (phase)
            1: set_rect(-32768, -32768, 32767, 32767);
            3: set_rect(x0, y0, x0, y0);
            4: set_rect(x1, y1, x0, y0);
            5: set_rect(32767, 32767, -32768, -32768);
            6: set_rect(-32768, 32767 - int'($urandom_range(0, 300)),
                        -32768 + int'($urandom_range(0, 300)), 32767);
            default: set_rect(x0, y0, x1, y1);
         endcase
         if (phase == 2) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 34;
            rsp_idle_pct = 34;
         end
         edges = 0;
         paused = 1'b0;
         if (phase == 3) begin
            // Single-edge objects while the receiver holds off fill the block.
            hold_trigger <= ~hold_trigger;
            req_idle_pct = 0;
            repeat (60) send_random_object(1, edges);
            req_idle_pct = 34;
         end
         while (edges < PHASE_EDGES) begin
            if (phase == 4 && !paused && edges >= PHASE_EDGES / 2) begin
               req_tvalid <= 1'b0;
               while (tracker.outstanding() != 0) @(posedge clock);
               paused = 1'b1;
            end
            send_random_object(6, edges);
         end
      end

      settle();
      if (tracker.errors == 0 && tracker.outstanding() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
